FILE: rtl/pli_pkg.sv
// Shared types and codes for the positional list block.
package pli_pkg;

  // Command codes on cmd_i.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Status codes on status_o.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Field widths fixed by the interface.
  localparam int unsigned DataW  = 8;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CountW = 8;

  // What one storage cell does at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_e;

  // Control that the list controller hands to each cell.
  typedef struct packed {
    cell_op_e op;
    logic     at_pos;
  } cell_ctrl_t;

endpackage

FILE: rtl/positional_list_insert_delete.sv
// Top level of the positional list: controller, cell chain and result register.
//
// An ordered list of up to CAPACITY bytes held in a row of cells. Each item
// (insert at a 1-based position, delete at a position, or clear) is taken on
// a clock edge where start_i is high and busy_o is low, and its result
// appears on the result ports for exactly one cycle, marked by done_o, in the
// cycle right after the item is taken. The whole chain shifts as the item is
// taken, so busy_o stays low and an item can be given every cycle; results
// follow in the same order, one per item. The receiver cannot stall results.
// A bad position gives status 1 and a full list on insert gives status 2; in
// both cases, and for an unused command code (status 1), the list is unchanged.
// After reset the list is empty, with no clearing pass.
module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   cmd_i,
  input  logic [pli_pkg::PosW-1:0]     position_i,
  input  logic [pli_pkg::DataW-1:0]    value_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [pli_pkg::DataW-1:0]    removed_value_o,
  output logic [pli_pkg::CountW-1:0]   count_o,
  output logic                         is_empty_o
);
  import pli_pkg::*;

  // Count needs to hold CAPACITY itself; compares run one bit wider still.
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW + 1 > PosW + 1) ? CntW + 1 : PosW + 1;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CmpW-1:0]  pos_w, cnt_w, idx_w;
  logic             pos_zero, ins_bad, del_bad, is_full;
  logic             do_ins, do_del;
  logic [1:0]       status_d;
  logic [DataW-1:0] removed_d;

  logic             done_q;
  logic [1:0]       status_q;
  logic [DataW-1:0] removed_q;
  logic [CountW-1:0] count_q;
  logic             empty_q;

  cell_ctrl_t       ctrl   [CAPACITY];
  logic [DataW-1:0] data   [CAPACITY];
  logic [DataW-1:0] sel    [CAPACITY];

  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Position checks against the current length.
  assign pos_w    = CmpW'(position_i);
  assign cnt_w    = CmpW'(cnt_q);
  assign idx_w    = pos_w - CmpW'(1);
  assign pos_zero = (position_i == '0);
  assign ins_bad  = pos_zero || (pos_w > cnt_w + CmpW'(1));
  assign del_bad  = pos_zero || (pos_w > cnt_w);
  assign is_full  = (cnt_w == CmpW'(CAPACITY));

  // Decode the command into status, new length and shift direction.
  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    cnt_d    = cnt_q;
    status_d = ST_BAD_POS;
    unique case (cmd_i)
      CMD_INSERT: begin
        if (ins_bad) begin
          status_d = ST_BAD_POS;
        end else if (is_full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          do_ins   = accept;
          cnt_d    = cnt_q + CntW'(1);
        end
      end
      CMD_DELETE: begin
        if (del_bad) begin
          status_d = ST_BAD_POS;
        end else begin
          status_d = ST_OK;
          do_del   = accept;
          cnt_d    = cnt_q - CntW'(1);
        end
      end
      CMD_CLEAR: begin
        status_d = ST_OK;
        cnt_d    = '0;
      end
      default: begin
        status_d = ST_BAD_POS;
      end
    endcase
  end

  // Per-cell control and the cell chain itself.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;

    always_comb begin
      ctrl[i].at_pos = (CmpW'(i) == idx_w);
      ctrl[i].op     = CELL_HOLD;
      if (do_ins) begin
        if (CmpW'(i) == idx_w) begin
          ctrl[i].op = CELL_LOAD;
        end else if (CmpW'(i) > idx_w) begin
          ctrl[i].op = CELL_LEFT;
        end
      end else if (do_del) begin
        if (CmpW'(i) >= idx_w) begin
          ctrl[i].op = CELL_RIGHT;
        end
      end
    end

    if (i == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = data[i];
    end else begin : g_mid_r
      assign right_w = data[i+1];
    end

    pli_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[i]),
      .value_i    (value_i),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (data[i]),
      .sel_data_o (sel[i])
    );
  end

  // Gather the addressed byte for a successful delete.
  always_comb begin
    removed_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed_d = removed_d | sel[i];
    end
    if (!(cmd_i == CMD_DELETE && !del_bad)) begin
      removed_d = '0;
    end
  end

  // Length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  // Result payload, captured with the item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      count_q   <= CountW'(cnt_d);
      empty_q   <= (cnt_d == '0);
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign count_o         = count_q;
  assign is_empty_o      = empty_q;

endmodule

FILE: rtl/pli_cell.sv
// One storage cell of the list: holds one byte and trades it with its neighbors.
module pli_cell (
  input  logic                       clk_i,
  input  pli_pkg::cell_ctrl_t        ctrl_i,
  input  logic [pli_pkg::DataW-1:0]  value_i,
  input  logic [pli_pkg::DataW-1:0]  left_i,
  input  logic [pli_pkg::DataW-1:0]  right_i,
  output logic [pli_pkg::DataW-1:0]  data_o,
  output logic [pli_pkg::DataW-1:0]  sel_data_o
);
  import pli_pkg::*;

  logic [DataW-1:0] data_q, data_d;

  // Pick the new content: keep, load the new byte, or take a neighbor's byte.
  always_comb begin
    case (ctrl_i.op)
      CELL_LOAD:  data_d = value_i;
      CELL_LEFT:  data_d = left_i;
      CELL_RIGHT: data_d = right_i;
      default:    data_d = data_q;
    endcase
  end

  // Payload register; no reset needed since unwritten cells are never read.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // The addressed cell puts its byte on the read-out OR tree; others give zero.
  assign sel_data_o = ctrl_i.at_pos ? data_q : '0;

endmodule
